// ===== rtl/ssm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssm_pkg: servo safety monitor shared definitions
// Word layouts, command codes, violation codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package ssm_pkg;

  localparam int unsigned InDataWidth  = 128;
  localparam int unsigned InUserWidth  = 2;
  localparam int unsigned OutDataWidth = 80;
  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned CfgDataWidth = 32;

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_KICK   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    VIOL_NONE     = 3'd0,
    VIOL_POSITION = 3'd1,
    VIOL_VELOCITY = 3'd2,
    VIOL_CURRENT  = 3'd3,
    VIOL_THERMAL  = 3'd4,
    VIOL_WATCHDOG = 3'd5
  } viol_e;

  typedef enum logic [CfgAddrWidth-1:0] {
    REG_POSITION_MIN   = 3'd0,
    REG_POSITION_MAX   = 3'd1,
    REG_VELOCITY_LIMIT = 3'd2,
    REG_CURRENT_LIMIT  = 3'd3,
    REG_OC_HOLD_MS     = 3'd4,
    REG_TEMP_LIMIT     = 3'd5,
    REG_WDG_TIMEOUT_MS = 3'd6,
    REG_CHECK_ENABLES  = 3'd7
  } reg_e;

  // check enable and sticky flag bit positions
  localparam int unsigned ChkPos = 0;
  localparam int unsigned ChkVel = 1;
  localparam int unsigned ChkCur = 2;
  localparam int unsigned ChkThm = 3;
  localparam int unsigned ChkWdg = 4;
  localparam int unsigned NumChecks = 5;

  typedef struct packed {
    logic [15:0] temperature;
    logic [15:0] motor_current;
    logic [31:0] velocity;
    logic [31:0] position;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [31:0]          clamped_velocity;
    logic [31:0]          clamped_position;
    logic [2:0]           viol_code;
    logic [NumChecks-1:0] flags;
    logic                 safe;
    logic                 status;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/servo_safety_monitor_top.sv =====
// ----------------------------------------------------------------------------
// servo_safety_monitor_top: servo protection monitor
// Checks servo samples against limits, keeps sticky flags, clamps outputs.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_axis: tuser carries the command (update, clear,
//   watchdog kick), tdata the timestamp and the sensor samples. Every accepted
//   word yields exactly one result word on m_axis with status, safe, the five
//   sticky flags, the last violation code and the clamped position/velocity.
//   Limits and check enables are written through the cfg_* port while the
//   block is idle; a write takes effect at the next clock edge.
//   An accepted word passes through the input register, then through the
//   check logic into the result register, where the monitor state is also
//   updated. Throughput is one word per cycle while the receiver does not
//   stall; the state update is a single pass of compares and two wrapped
//   subtractions, so words may follow back to back.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more word; s_axis_tready drops only when both
//   are full.
//   Reset clears both pipeline stages, loads the register defaults, clears
//   all flags and timers and leaves the monitor in the safe state.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_safety_monitor_top
  import ssm_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // tdata: time_ms[31:0], position[63:32], velocity[95:64],
  //        motor_current[111:96], temperature[127:112]
  input  wire logic [InDataWidth-1:0]  s_axis_tdata,
  // tuser: command[1:0]
  input  wire logic [InUserWidth-1:0]  s_axis_tuser,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: status[0], safe[1], position_flag[2], velocity_flag[3],
  //        current_flag[4], thermal_flag[5], watchdog_flag[6],
  //        viol_code[9:7], clamped_position[41:10],
  //        clamped_velocity[73:42], zero fill[79:74]
  output logic [OutDataWidth-1:0]      m_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgAddrWidth-1:0] cfg_addr_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i
);

  // configuration registers
  logic [31:0]          pos_min_q, pos_max_q;
  logic [30:0]          vel_limit_q;
  logic [15:0]          cur_limit_q, temp_limit_q;
  logic [31:0]          oc_hold_q, wdg_timeout_q;
  logic [NumChecks-1:0] enables_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_min_q     <= 32'h8000_0000;
      pos_max_q     <= 32'h7FFF_FFFF;
      vel_limit_q   <= 31'h7FFF_FFFF;
      cur_limit_q   <= 16'hFFFF;
      oc_hold_q     <= 32'd100;
      temp_limit_q  <= 16'hFFFF;
      wdg_timeout_q <= 32'd1000;
      enables_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_addr_i))
        REG_POSITION_MIN:   pos_min_q     <= cfg_data_i;
        REG_POSITION_MAX:   pos_max_q     <= cfg_data_i;
        REG_VELOCITY_LIMIT: vel_limit_q   <= cfg_data_i[30:0];
        REG_CURRENT_LIMIT:  cur_limit_q   <= cfg_data_i[15:0];
        REG_OC_HOLD_MS:     oc_hold_q     <= cfg_data_i;
        REG_TEMP_LIMIT:     temp_limit_q  <= cfg_data_i[15:0];
        REG_WDG_TIMEOUT_MS: wdg_timeout_q <= cfg_data_i;
        REG_CHECK_ENABLES:  enables_q     <= cfg_data_i[NumChecks-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic     in_valid_q, out_valid_q;
  in_item_t in_item_q;
  logic [1:0] in_cmd_q;
  result_t  result_q;
  logic     out_free, advance;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q <= in_item_t'(s_axis_tdata);
      in_cmd_q  <= s_axis_tuser;
    end
  end

  // monitor state
  logic [31:0]          oc_start_q, oc_start_d;
  logic                 oc_timing_q, oc_timing_d;
  logic [31:0]          last_upd_q, last_upd_d;
  logic                 upd_valid_q, upd_valid_d;
  logic [NumChecks-1:0] flags_q, flags_d;
  logic [2:0]           code_q, code_d;
  logic                 safe_q, safe_d;

  // check logic
  logic signed [31:0] pos_s, vel_s, pmin_s, pmax_s, vlim_s, vlim_neg_s;
  logic [31:0]        vel_neg, oc_start_eff, oc_gap, wdg_gap;
  logic [30:0]        vel_abs;
  logic               pos_low, pos_high;
  logic               pos_fail, vel_fail, cur_over, cur_fail, thm_fail, wdg_fail;
  logic               violation;
  logic [31:0]        cpos, cvel;

  always_comb begin
    pos_s      = $signed(in_item_q.position);
    vel_s      = $signed(in_item_q.velocity);
    pmin_s     = $signed(pos_min_q);
    pmax_s     = $signed(pos_max_q);
    vlim_s     = $signed({1'b0, vel_limit_q});
    vlim_neg_s = -vlim_s;
    pos_low    = pos_s < pmin_s;
    pos_high   = pos_s > pmax_s;

    // saturate the most negative velocity to the largest magnitude
    vel_neg = ~in_item_q.velocity + 32'd1;
    if (!in_item_q.velocity[31]) begin
      vel_abs = in_item_q.velocity[30:0];
    end else if (in_item_q.velocity == 32'h8000_0000) begin
      vel_abs = '1;
    end else begin
      vel_abs = vel_neg[30:0];
    end

    cur_over     = in_item_q.motor_current > cur_limit_q;
    oc_start_eff = oc_timing_q ? oc_start_q : in_item_q.time_ms;
    oc_gap       = in_item_q.time_ms - oc_start_eff;
    wdg_gap      = in_item_q.time_ms - last_upd_q;

    pos_fail = enables_q[ChkPos] && (pos_low || pos_high);
    vel_fail = enables_q[ChkVel] && (vel_abs > vel_limit_q);
    cur_fail = enables_q[ChkCur] && cur_over && (oc_gap > oc_hold_q);
    thm_fail = enables_q[ChkThm] && (in_item_q.temperature > temp_limit_q);
    wdg_fail = enables_q[ChkWdg] && upd_valid_q && (wdg_gap > wdg_timeout_q);

    oc_start_d  = oc_start_q;
    oc_timing_d = oc_timing_q;
    last_upd_d  = last_upd_q;
    upd_valid_d = upd_valid_q;
    flags_d     = flags_q;
    code_d      = code_q;
    safe_d      = safe_q;
    violation   = 1'b0;

    unique case (in_cmd_q)
      CMD_UPDATE: begin
        violation = pos_fail || vel_fail || cur_fail || thm_fail || wdg_fail;
        flags_d   = flags_q | {wdg_fail, thm_fail, cur_fail, vel_fail, pos_fail};
        // the last failing check in order wins
        priority if (wdg_fail) code_d = VIOL_WATCHDOG;
        else if (thm_fail)     code_d = VIOL_THERMAL;
        else if (cur_fail)     code_d = VIOL_CURRENT;
        else if (vel_fail)     code_d = VIOL_VELOCITY;
        else if (pos_fail)     code_d = VIOL_POSITION;
        else                   code_d = code_q;
        if (enables_q[ChkCur]) begin
          oc_start_d  = oc_start_eff;
          oc_timing_d = cur_over;
        end
        last_upd_d  = in_item_q.time_ms;
        upd_valid_d = 1'b1;
        safe_d      = !violation;
      end
      CMD_CLEAR: begin
        flags_d     = '0;
        safe_d      = 1'b1;
        code_d      = VIOL_NONE;
        oc_timing_d = 1'b0;
      end
      CMD_KICK: begin
        last_upd_d      = in_item_q.time_ms;
        upd_valid_d     = 1'b1;
        flags_d[ChkWdg] = 1'b0;
      end
      default: ;
    endcase

    cpos = in_item_q.position;
    if (enables_q[ChkPos]) begin
      priority if (pos_low) cpos = pos_min_q;
      else if (pos_high)    cpos = pos_max_q;
      else                  cpos = in_item_q.position;
    end
    cvel = in_item_q.velocity;
    if (enables_q[ChkVel]) begin
      priority if (vel_s < vlim_neg_s) cvel = vlim_neg_s;
      else if (vel_s > vlim_s)         cvel = vlim_s;
      else                             cvel = in_item_q.velocity;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oc_start_q  <= '0;
      oc_timing_q <= 1'b0;
      last_upd_q  <= '0;
      upd_valid_q <= 1'b0;
      flags_q     <= '0;
      code_q      <= VIOL_NONE;
      safe_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        oc_start_q  <= oc_start_d;
        oc_timing_q <= oc_timing_d;
        last_upd_q  <= last_upd_d;
        upd_valid_q <= upd_valid_d;
        flags_q     <= flags_d;
        code_q      <= code_d;
        safe_q      <= safe_d;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q.status           <= violation;
      result_q.safe             <= safe_d;
      result_q.flags            <= flags_d;
      result_q.viol_code        <= code_d;
      result_q.clamped_position <= cpos;
      result_q.clamped_velocity <= cvel;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataWidth - $bits(result_t)){1'b0}}, result_q};

  // assertions
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled while a stage was free");

  a_status_not_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(result_q.status && result_q.safe))
    else $error("violation reported as safe");

  a_status_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && result_q.status) |-> (result_q.viol_code != VIOL_NONE))
    else $error("violation without a code");

  a_code_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (code_q == VIOL_POSITION) |-> flags_q[ChkPos])
    else $error("position code without its flag");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_q <= VIOL_WATCHDOG)
    else $error("last violation code out of range");

endmodule

`default_nettype wire
